[rtl/core/ekcd_pkg.sv]
package ekcd_pkg;

   // Number of combination slots that are looked at. Slots beyond the four
   // code registers count as unused.
   localparam int COMBO_SLOTS = 4;
   localparam int NUM_CODE_REGS = 4;

   // Codes at or above this base are mouse buttons and never allowed extras.
   localparam int MOUSE_BASE = 256;

   typedef logic signed [9:0] code_type;
   typedef logic [19:0] delay_type;
   typedef logic [21:0] timer_type;

   localparam code_type CODE_UNUSED = 10'sh3FF;
   localparam delay_type DELAY_RESET = 20'd100000;

   // Movement keys that may be held without breaking exclusivity.
   localparam logic [8:0] KEY_W = 9'h011;
   localparam logic [8:0] KEY_A = 9'h01E;
   localparam logic [8:0] KEY_S = 9'h01F;
   localparam logic [8:0] KEY_D = 9'h020;

   // Configuration register indexes.
   localparam logic [2:0] REG_CODE_A = 3'd0;
   localparam logic [2:0] REG_CODE_B = 3'd1;
   localparam logic [2:0] REG_CODE_C = 3'd2;
   localparam logic [2:0] REG_CODE_D = 3'd3;
   localparam logic [2:0] REG_DELAY  = 3'd4;

   // Request kinds carried in tuser.
   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Everything the tick decision needs.
   typedef struct packed {
      logic      combo_now;
      logic      no_foreign;
      logic      need_excl;
      logic [19:0] dt;
      logic      suppress;
      logic      set_suppress;
      logic      accepted;
      logic      prev_raw;
      logic      armed;
      timer_type timer;
      delay_type delay;
   } eval_in_type;

   // Next detector state plus the event pulses of the tick.
   typedef struct packed {
      logic      accepted;
      logic      prev_raw;
      logic      suppress;
      logic      armed;
      timer_type timer;
      logic      pressed;
      logic      released;
   } eval_out_type;

endpackage

[rtl/core/exclusive_key_combo_detector.sv]
// Key events may be accepted back to back while the detector is idle.
// A tick scans every key code with one read of the key-down memory per
// cycle, then a drain state takes the last read and a finish state decides
// once the output register is free. The result waits in that register while
// key events keep flowing. After reset a clearing pass writes KEY_CODES zero
// entries into the key-down memory; req_tready stays low during the pass.
module exclusive_key_combo_detector #(
   parameter int KEY_CODES = 512
) (
   input  logic        clock,
   input  logic        reset,
   // Requests.
   input  logic        req_tvalid,
   output logic        req_tready,
   // key_code[8:0], key_pressed[9], tick_us[29:10], need_exclusive[30],
   // blocked_in[31], set_suppress[32], zero fill[39:33]
   input  logic [39:0] req_tdata,
   // req_type[0]
   input  logic [0:0]  req_tuser,
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // hotkey_level[0], pressed_pulse[1], released_pulse[2], blocked_out[3],
   // zero fill[7:4]
   output logic [7:0]  rsp_tdata,
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam int AW = $clog2(KEY_CODES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_CODES - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;

   // Configuration registers.
   ekcd_pkg::code_type  code_ff [ekcd_pkg::NUM_CODE_REGS];
   ekcd_pkg::delay_type delay_ff;

   // Detector state.
   logic                accepted_ff, prev_raw_ff, suppress_ff, armed_ff;
   ekcd_pkg::timer_type timer_ff;

   // Latched tick fields.
   logic [19:0] dt_ff;
   logic        excl_ff, blocked_ff, set_sup_ff;

   // Scan accumulators.
   logic                                foreign_ff, foreign_in;
   logic [ekcd_pkg::NUM_CODE_REGS-1:0] found_ff, found_in;
   logic                                rd_pend_ff;
   logic [AW-1:0]                       rd_tag_ff;

   // Key-down memory.
   logic mem [KEY_CODES];
   logic          mem_we, mem_wd, rd_data_ff;
   logic [AW-1:0] mem_wa;

   logic       rsp_valid_ff;
   logic [3:0] rsp_data_ff;

   logic req_fire, key_fire, tick_fire, finish_go;
   logic [8:0] key_code;
   logic       key_ok;
   logic       combo_now;
   logic [ekcd_pkg::NUM_CODE_REGS-1:0] slot_used, slot_valid, slot_hit;
   logic       in_combo, allowed_extra;

   ekcd_pkg::eval_in_type  ev_in;
   ekcd_pkg::eval_out_type ev_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign key_fire   = req_fire && (req_tuser[0] == ekcd_pkg::REQ_KEY);
   assign tick_fire  = req_fire && (req_tuser[0] == ekcd_pkg::REQ_TICK);
   assign finish_go  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   assign key_code = req_tdata[8:0];
   assign key_ok   = (32'(key_code) < KEY_CODES);

   // Sequencer: clearing pass, idle, scan of all key codes, drain, decision.
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            addr_in = '0;
            if (tick_fire) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (finish_go) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // Memory write port: zero fill during the clearing pass, key events later.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = 1'b0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (key_fire && key_ok) begin
         mem_we = 1'b1;
         mem_wa = AW'(key_code);
         mem_wd = req_tdata[9];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[addr_ff];
      rd_tag_ff  <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rd_pend_ff <= 1'b0;
      else       rd_pend_ff <= (state_ff == ST_SCAN);
   end

   // Slot decode: used, legal and matching the key code of the read word.
   always_comb begin
      for (int i = 0; i < ekcd_pkg::NUM_CODE_REGS; i++) begin
         slot_used[i]  = (i < ekcd_pkg::COMBO_SLOTS) &&
                         (code_ff[i] != ekcd_pkg::CODE_UNUSED);
         slot_valid[i] = !code_ff[i][9] && (32'(code_ff[i][8:0]) < KEY_CODES);
         slot_hit[i]   = (i < ekcd_pkg::COMBO_SLOTS) && !code_ff[i][9] &&
                         (32'(code_ff[i][8:0]) == 32'(rd_tag_ff));
      end
   end

   assign in_combo      = |slot_hit;
   assign allowed_extra = (32'(rd_tag_ff) < ekcd_pkg::MOUSE_BASE) &&
                          ((32'(rd_tag_ff) == 32'(ekcd_pkg::KEY_W)) ||
                           (32'(rd_tag_ff) == 32'(ekcd_pkg::KEY_A)) ||
                           (32'(rd_tag_ff) == 32'(ekcd_pkg::KEY_S)) ||
                           (32'(rd_tag_ff) == 32'(ekcd_pkg::KEY_D)));

   // Accumulate foreign keys and combination hits over the scan.
   always_comb begin
      foreign_in = foreign_ff;
      found_in   = found_ff;
      if (tick_fire) begin
         foreign_in = 1'b0;
         found_in   = '0;
      end else if (rd_pend_ff && rd_data_ff) begin
         found_in = found_ff | slot_hit;
         if (!in_combo && !allowed_extra) foreign_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      foreign_ff <= foreign_in;
      found_ff   <= found_in;
   end

   // The combination is down when at least one slot is used and every used
   // slot holds a legal code whose key is down.
   always_comb begin
      logic any_used;
      logic all_ok;
      any_used = 1'b0;
      all_ok   = 1'b1;
      for (int i = 0; i < ekcd_pkg::NUM_CODE_REGS; i++) begin
         if (slot_used[i]) begin
            any_used = 1'b1;
            if (!(slot_valid[i] && found_ff[i])) all_ok = 1'b0;
         end
      end
      combo_now = any_used && all_ok;
   end

   // Latch the tick fields.
   always_ff @(posedge clock) begin
      if (tick_fire) begin
         dt_ff      <= req_tdata[29:10];
         excl_ff    <= req_tdata[30];
         blocked_ff <= req_tdata[31];
         set_sup_ff <= req_tdata[32];
      end
   end

   assign ev_in.combo_now    = combo_now;
   assign ev_in.no_foreign   = !foreign_ff;
   assign ev_in.need_excl    = excl_ff;
   assign ev_in.dt           = dt_ff;
   assign ev_in.suppress     = suppress_ff;
   assign ev_in.set_suppress = set_sup_ff;
   assign ev_in.accepted     = accepted_ff;
   assign ev_in.prev_raw     = prev_raw_ff;
   assign ev_in.armed        = armed_ff;
   assign ev_in.timer        = timer_ff;
   assign ev_in.delay        = delay_ff;

   ekcd_eval u_eval (
      .eval_i (ev_in),
      .eval_o (ev_out)
   );

   // Detector state update at the end of a tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= 1'b0;
         prev_raw_ff <= 1'b0;
         suppress_ff <= 1'b0;
         armed_ff    <= 1'b0;
         timer_ff    <= '0;
      end else if (finish_go) begin
         accepted_ff <= ev_out.accepted;
         prev_raw_ff <= ev_out.prev_raw;
         suppress_ff <= ev_out.suppress;
         armed_ff    <= ev_out.armed;
         timer_ff    <= ev_out.timer;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_data_ff <= {blocked_ff, ev_out.released, ev_out.pressed, ev_out.accepted};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ekcd_pkg::NUM_CODE_REGS; i++) begin
            code_ff[i] <= ekcd_pkg::CODE_UNUSED;
         end
         delay_ff <= ekcd_pkg::DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ekcd_pkg::REG_CODE_A: code_ff[0] <= csr_data[9:0];
            ekcd_pkg::REG_CODE_B: code_ff[1] <= csr_data[9:0];
            ekcd_pkg::REG_CODE_C: code_ff[2] <= csr_data[9:0];
            ekcd_pkg::REG_CODE_D: code_ff[3] <= csr_data[9:0];
            ekcd_pkg::REG_DELAY:  delay_ff   <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

[rtl/core/ekcd_eval.sv]
module ekcd_eval (
   input  ekcd_pkg::eval_in_type  eval_i,
   output ekcd_pkg::eval_out_type eval_o
);

   logic              edge_rise;
   logic              sup;
   logic              acc;
   logic signed [22:0] t_left;

   // Remaining confirm time after this tick, as a signed value.
   assign t_left = $signed({1'b0, eval_i.timer}) - $signed({3'b000, eval_i.dt});

   assign edge_rise = eval_i.combo_now && !eval_i.prev_raw;
   assign sup       = eval_i.suppress || eval_i.set_suppress;

   // Tick decision: suppression first, then the non-exclusive path, then the exclusive confirm logic.
   always_comb begin
      acc             = 1'b0;
      eval_o.armed    = eval_i.armed;
      eval_o.timer    = eval_i.timer;
      eval_o.suppress = sup;
      if (sup) begin
         eval_o.armed    = 1'b0;
         eval_o.timer    = '0;
         eval_o.suppress = eval_i.combo_now;
      end else if (!eval_i.need_excl) begin
         eval_o.armed = 1'b0;
         eval_o.timer = '0;
         acc          = eval_i.combo_now;
      end else if (eval_i.accepted) begin
         acc = eval_i.combo_now;
      end else if (!eval_i.armed) begin
         if (edge_rise && eval_i.no_foreign) begin
            eval_o.armed = 1'b1;
            eval_o.timer = 22'(eval_i.delay);
         end
      end else if (!eval_i.no_foreign) begin
         eval_o.armed = 1'b0;
         eval_o.timer = '0;
      end else if (!eval_i.combo_now) begin
         eval_o.armed = 1'b0;
         eval_o.timer = '0;
         acc          = 1'b1;
      end else if (t_left[22] || (t_left == '0)) begin
         eval_o.armed = 1'b0;
         eval_o.timer = '0;
         acc          = 1'b1;
      end else begin
         eval_o.timer = t_left[21:0];
      end

      // Level, raw combination history and the event pulses of the tick.
      eval_o.accepted = acc;
      eval_o.prev_raw = eval_i.combo_now;
      eval_o.pressed  = !sup && acc && !eval_i.accepted;
      eval_o.released = !sup && !acc && eval_i.accepted;
   end

endmodule

[rtl/core/ekcd_checker.sv]
module ekcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [0:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // A press pulse comes with an accepted level, a release pulse without.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[1] || rsp_tdata[0]) && (!rsp_tdata[2] || !rsp_tdata[0]))
      else $error("pulse disagrees with level");

   // Never both pulses in one word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("press and release pulse together");

   // The clearing pass after reset holds off requests.
   assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // An accepted tick starts a scan, so the next word waits.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == ekcd_pkg::REQ_TICK) |=> !req_tready)
      else $error("request taken during tick scan");

endmodule

bind exclusive_key_combo_detector ekcd_checker u_ekcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
